// File: src/min_max_normalize_to_byte_unit_assert.svh
// Assertion macros shared by the normalizer RTL.
// Needs nothing else; files that check properties include it by name.
`ifndef MIN_MAX_NORMALIZE_TO_BYTE_UNIT_ASSERT_SVH
`define MIN_MAX_NORMALIZE_TO_BYTE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define MMNB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("property violated");
// Next-cycle implication, disabled while reset is asserted
`define MMNB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("property violated");
`else
`define MMNB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MMNB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/mmnb_pkg.sv
// Shared types and constants of the min-max byte normalizer.
// No dependencies; imported by the controller, datapath and top level.
package mmnb_pkg;

	// fixed field widths
	localparam int VOXEL_W = 32;
	localparam int KIND_W  = 2;
	localparam int LEVEL_W = 8;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MEASURE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CONVERT = 2'd2;

	localparam logic [LEVEL_W-1:0] FULL_SCALE = 8'd255;

	// one quotient bit per divider step
	localparam int                 STEP_W    = 3;
	localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(LEVEL_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_INIT,
		ST_DIV,
		ST_FINISH
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture convert voxel
		logic clear;     // reset tracked range
		logic measure;   // fold voxel into range
		logic prep;      // offsets and range flags
		logic init;      // load dividend and divisor
		logic step;      // one restoring division step
		logic load_out;  // write result register
	} cmd_t;

endpackage

// File: src/mmnb_in_if.sv
// Input channel of the normalizer: kind and voxel with valid/ready.
// Depends on mmnb_pkg for field widths.
interface mmnb_in_if import mmnb_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [KIND_W-1:0]         kind;
	logic signed [VOXEL_W-1:0] voxel;

	modport source (output valid, output kind, output voxel, input ready);
	modport sink (input valid, input kind, input voxel, output ready);
endinterface

// File: src/mmnb_out_if.sv
// Result channel of the normalizer: level and flat flag with valid/ready.
// Depends on mmnb_pkg for field widths.
interface mmnb_out_if import mmnb_pkg::*;;
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] level;
	logic               flat_range;

	modport source (output valid, output level, output flat_range, input ready);
	modport sink (input valid, input level, input flat_range, output ready);
endinterface

// File: src/mmnb_ctrl.sv
// Controller of the normalizer: sequences range updates and the divider.
// Depends on mmnb_pkg and the assertion macro header.
`include "min_max_normalize_to_byte_unit_assert.svh"
module mmnb_ctrl import mmnb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [KIND_W-1:0] in_kind,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output cmd_t              cmd
);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              accept;
	logic              slot_free;

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_kind == KIND_CONVERT) state_d = ST_PREP;
			end
			ST_PREP:   state_d = ST_INIT;
			ST_INIT:   state_d = ST_DIV;
			ST_DIV: begin
				if (step_q == STEP_LAST) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = out_valid_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load    = accept && in_kind == KIND_CONVERT;
				cmd.clear   = accept && in_kind == KIND_CLEAR;
				cmd.measure = accept && in_kind == KIND_MEASURE;
			end
			ST_PREP:   cmd.prep = 1'b1;
			ST_INIT:   cmd.init = 1'b1;
			ST_DIV:    cmd.step = 1'b1;
			ST_FINISH: cmd.load_out = slot_free;
			default:   cmd = '0;
		endcase
	end

	// state, step counter, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.init) step_q <= '0;
			else if (cmd.step) step_q <= step_q + 1'b1;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	`MMNB_ASSERT_IMPL(a_load_out_free, clk, arst_n, cmd.load_out, !out_valid_q || out_ready)
	`MMNB_ASSERT_NEXT(a_div_len, clk, arst_n, state_q == ST_DIV && step_q == STEP_LAST, state_q == ST_FINISH)
	`MMNB_ASSERT_IMPL(a_valid_drop, clk, arst_n, $fell(out_valid_q), $past(out_ready))

endmodule

// File: src/mmnb_datapath.sv
// Datapath of the normalizer: range registers, offset logic, restoring
// divider and result register. Depends on mmnb_pkg and the assertion header.
`include "min_max_normalize_to_byte_unit_assert.svh"
module mmnb_datapath import mmnb_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	input  logic signed [VOXEL_W-1:0] voxel,
	output logic [LEVEL_W-1:0]        level,
	output logic                      flat_range
);

	localparam int NUM_W = VALUE_WIDTH + LEVEL_W;
	localparam logic signed [VALUE_WIDTH-1:0] MOST_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic signed [VALUE_WIDTH-1:0] MOST_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	logic signed [VALUE_WIDTH-1:0] vin;
	logic signed [VALUE_WIDTH-1:0] range_low_q, range_high_q;
	logic signed [VALUE_WIDTH-1:0] v_q;
	logic signed [VALUE_WIDTH:0]   d_full, r_full;
	logic [VALUE_WIDTH-1:0]        d_q, r_q;
	logic                          flat_q, below_q, above_q;
	logic [NUM_W-1:0]              rem_q, div_q;
	logic [NUM_W:0]                trial;
	logic [LEVEL_W-1:0]            quot_q;
	logic [LEVEL_W-1:0]            level_q;
	logic                          flat_out_q;

	// voxel taken as a VALUE_WIDTH two's complement number
	assign vin = VALUE_WIDTH'(voxel);

	// tracked range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= MOST_POS;
			range_high_q <= MOST_NEG;
		end else if (cmd.clear) begin
			range_low_q  <= MOST_POS;
			range_high_q <= MOST_NEG;
		end else if (cmd.measure) begin
			if (vin > range_high_q) range_high_q <= vin;
			if (vin < range_low_q) range_low_q <= vin;
		end
	end

	// offsets from the minimum, one bit wider so they cannot overflow
	assign d_full = (VALUE_WIDTH+1)'(v_q) - (VALUE_WIDTH+1)'(range_low_q);
	assign r_full = (VALUE_WIDTH+1)'(range_high_q) - (VALUE_WIDTH+1)'(range_low_q);

	// trial subtract of the restoring divider
	assign trial = {1'b0, rem_q} - {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (cmd.load) v_q <= vin;
		// both offsets are below 2^VALUE_WIDTH when they are used
		if (cmd.prep) begin
			d_q     <= d_full[VALUE_WIDTH-1:0];
			r_q     <= r_full[VALUE_WIDTH-1:0];
			flat_q  <= !(range_high_q > range_low_q);
			below_q <= v_q <= range_low_q;
			above_q <= v_q >= range_high_q;
		end
		// dividend 255*d, divisor r aligned to the top quotient bit
		if (cmd.init) begin
			rem_q  <= (NUM_W'(d_q) << LEVEL_W) - NUM_W'(d_q);
			div_q  <= NUM_W'(r_q) << (LEVEL_W - 1);
			quot_q <= '0;
		end else if (cmd.step) begin
			if (!trial[NUM_W]) rem_q <= trial[NUM_W-1:0];
			quot_q <= {quot_q[LEVEL_W-2:0], !trial[NUM_W]};
			div_q  <= div_q >> 1;
		end
		// saturate outside the range, zero on a flat range
		if (cmd.load_out) begin
			priority if (flat_q || below_q) level_q <= '0;
			else if (above_q) level_q <= FULL_SCALE;
			else level_q <= quot_q;
			flat_out_q <= flat_q;
		end
	end

	assign level      = level_q;
	assign flat_range = flat_out_q;

	`MMNB_ASSERT_NEXT(a_range_order, clk, arst_n, cmd.measure, range_low_q <= range_high_q)

endmodule

// File: src/min_max_normalize_to_byte_unit.sv
// Min-max byte normalizer top level; uses mmnb_pkg, mmnb_in_if, mmnb_out_if,
// mmnb_ctrl and mmnb_datapath. Clear and measure are taken while idle and give no result.
// Convert: steps through PREP, INIT, the 8-step restoring divider (one quotient bit a
// cycle) and FINISH, which waits for a free result slot; no item is accepted meanwhile.
// Reset (arst_n low) sets the range to empty and drops any pending result.
`include "min_max_normalize_to_byte_unit_assert.svh"
module min_max_normalize_to_byte_unit import mmnb_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input logic         clk,
	input logic         arst_n,
	mmnb_in_if.sink     item,
	mmnb_out_if.source  result
);

	cmd_t cmd;

	// sequencing
	mmnb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_kind   (item.kind),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	// arithmetic and storage
	mmnb_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.voxel      (item.voxel),
		.level      (result.level),
		.flat_range (result.flat_range)
	);

	`MMNB_ASSERT_IMPL(a_flat_zero, clk, arst_n, result.valid && result.flat_range, result.level == '0)

endmodule
